@@ src/tcpu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcpu_pkg
// Shared types and constants for the execute unit.
// ----------------------------------------------------------------------------
package tcpu_pkg;

  localparam int unsigned RegIdxW = 4;
  localparam logic [RegIdxW-1:0] PcIdx = 4'd15;
  localparam logic [RegIdxW-1:0] LrIdx = 4'd14;

  typedef enum logic [3:0] {
    OP_LDR = 4'd0, OP_STR = 4'd1, OP_LDX = 4'd2, OP_STX = 4'd3,
    OP_MOV = 4'd4, OP_ADD = 4'd5, OP_SUB = 4'd6, OP_MUL = 4'd7,
    OP_DIV = 4'd8, OP_AND = 4'd9, OP_ORR = 4'd10, OP_EOR = 4'd11,
    OP_CMP = 4'd12, OP_BR = 4'd13, OP_NOP14 = 4'd14, OP_NOP15 = 4'd15
  } opcode_e;

  typedef enum logic [2:0] {
    BC_AL = 3'd0, BC_EQ = 3'd1, BC_NE = 3'd2, BC_LE = 3'd3,
    BC_LT = 3'd4, BC_GE = 3'd5, BC_GT = 3'd6, BC_BL = 3'd7
  } cond_e;

  typedef enum logic [1:0] {
    BUS_NONE = 2'd0, BUS_READ = 2'd1, BUS_WRITE = 2'd2
  } bus_req_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_BUSY = 2'd1, ST_NOLOAD = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE, CS_DIV, CS_DONE
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch operands of accepted beat
    logic div_start;
    logic div_step;
    logic commit;     // update architectural state and result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_div;
    logic div_last;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ src/tiny_cpu_execute_unit_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tiny_cpu_execute_unit_top
// Execute stage with register file, flags, load tracking and serial divide.
// ----------------------------------------------------------------------------
// channel  direction  handshake
// in       input      in_valid_i / in_stall_o
// out      output     out_valid_o / out_stall_i
//
// a DIV yields one quotient bit a cycle
// one item at a time; the next is taken once the result is committed
// the result register lets input proceed while a beat waits on out_stall_i
// reset clears the register file, flags and pending load
module tiny_cpu_execute_unit_top import tcpu_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  logic               in_valid_i,
  output logic                     in_stall_o,
  input  wire  logic               command_i,
  input  wire  logic [3:0]         opcode_i,
  input  wire  logic [2:0]         branch_condition_i,
  input  wire  logic [3:0]         dest_reg_i,
  input  wire  logic [3:0]         first_reg_i,
  input  wire  logic [3:0]         second_reg_i,
  input  wire  logic               use_register_i,
  input  wire  logic signed [31:0] immediate_i,
  input  wire  logic [31:0]        target_address_i,
  input  wire  logic signed [31:0] base_offset_i,
  input  wire  logic signed [31:0] load_data_i,
  output logic                     out_valid_o,
  input  wire  logic               out_stall_i,
  output logic [31:0]              next_pc_o,
  output logic [1:0]               bus_request_o,
  output logic [31:0]              bus_address_o,
  output logic signed [31:0]       bus_write_data_o,
  output logic                     negative_flag_o,
  output logic                     zero_flag_o,
  output logic [1:0]               status_o
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  tcpu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  tcpu_datapath #(.DataWidth(DATA_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .command_i, .opcode_i, .branch_condition_i, .dest_reg_i, .first_reg_i,
    .second_reg_i, .use_register_i, .immediate_i, .target_address_i,
    .base_offset_i, .load_data_i, .next_pc_o, .bus_request_o, .bus_address_o,
    .bus_write_data_o, .negative_flag_o, .zero_flag_o, .status_o
  );

endmodule
`default_nettype wire

@@ src/tcpu_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcpu_datapath
// Register file, flags, ALU, serial divider and result registers.
// ----------------------------------------------------------------------------
module tcpu_datapath import tcpu_pkg::*; #(
  parameter int unsigned DataWidth = 32
) (
  input  wire  logic                 clk_i,
  input  wire  logic                 rst_ni,
  input  wire  dp_cmd_t              cmd_i,
  output dp_stat_t                   stat_o,
  input  wire  logic                 command_i,
  input  wire  logic [3:0]           opcode_i,
  input  wire  logic [2:0]           branch_condition_i,
  input  wire  logic [3:0]           dest_reg_i,
  input  wire  logic [3:0]           first_reg_i,
  input  wire  logic [3:0]           second_reg_i,
  input  wire  logic                 use_register_i,
  input  wire  logic signed [31:0]   immediate_i,
  input  wire  logic [31:0]          target_address_i,
  input  wire  logic signed [31:0]   base_offset_i,
  input  wire  logic signed [31:0]   load_data_i,
  output logic [31:0]                next_pc_o,
  output logic [1:0]                 bus_request_o,
  output logic [31:0]                bus_address_o,
  output logic signed [31:0]         bus_write_data_o,
  output logic                       negative_flag_o,
  output logic                       zero_flag_o,
  output logic [1:0]                 status_o
);
  localparam int unsigned W = DataWidth;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0] rf_q [16];
  logic         n_q, z_q, pend_q;
  logic [3:0]   ldst_q;

  // captured beat
  logic         cmd_q, usr_q;
  opcode_e      op_q;
  cond_e        cond_q;
  logic [3:0]   rd_q;
  logic [W-1:0] a_q, b_q, d_q, imm_q, tgt_q, off_q, ld_q;

  // divider
  logic [W-1:0] quo_q, rem_q, dvs_q;
  logic [CntW-1:0] cnt_q;
  logic         qneg_q;

  function automatic logic [W-1:0] wid(input logic [31:0] v);
    logic [W-1:0] r;
    r = '0;
    for (int i = 0; i < W; i++) r[i] = (i < 32) ? v[i] : v[31];
    return r;
  endfunction

  function automatic logic [W-1:0] zwid(input logic [31:0] v);
    logic [W-1:0] r;
    r = '0;
    for (int i = 0; i < W && i < 32; i++) r[i] = v[i];
    return r;
  endfunction

  function automatic logic [31:0] nar(input logic [W-1:0] v);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < W && i < 32; i++) r[i] = v[i];
    return r;
  endfunction

  assign stat_o.needs_div = (command_i == 1'b0) && !pend_q && (opcode_i == OP_DIV);
  assign stat_o.div_last  = (cnt_q == CntW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= command_i;
      op_q   <= opcode_e'(opcode_i);
      cond_q <= cond_e'(branch_condition_i);
      rd_q   <= dest_reg_i;
      usr_q  <= use_register_i;
      a_q    <= rf_q[second_reg_i];
      b_q    <= rf_q[first_reg_i];
      d_q    <= rf_q[dest_reg_i];
      imm_q  <= wid(immediate_i);
      tgt_q  <= zwid(target_address_i);
      off_q  <= wid(base_offset_i);
      ld_q   <= wid(load_data_i);
    end
  end

  // restoring divider, one quotient bit per cycle on magnitudes
  logic [W:0] trial;
  assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      quo_q  <= a_q[W-1] ? (~a_q + 1'b1) : a_q;
      dvs_q  <= b_q[W-1] ? (~b_q + 1'b1) : b_q;
      rem_q  <= '0;
      qneg_q <= a_q[W-1] ^ b_q[W-1];
      cnt_q  <= CntW'(W);
    end else if (cmd_i.div_step) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[W-2:0], quo_q[W-1]};
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  logic [W-1:0] pc, pc4, r, v, quot, addr, wdata, nxt;
  logic [1:0]   req, st;
  logic         alu, take, set_f, wr_rf, wr_lr, n_d, z_d, pend_d;
  logic [3:0]   wr_idx;
  logic [W-1:0] wr_val;
  logic [2*W-1:0] prod;

  assign prod = a_q * b_q;
  assign quot = (dvs_q == '0) ? '0 : (qneg_q ? (~quo_q + 1'b1) : quo_q);

  always_comb begin
    pc = rf_q[PcIdx];
    pc4 = pc + W'(4);
    nxt = pc4; req = BUS_NONE; addr = '0; wdata = '0; st = ST_OK;
    r = '0; alu = 1'b0; take = 1'b0; set_f = 1'b0; wr_rf = 1'b0; wr_lr = 1'b0;
    wr_idx = rd_q; wr_val = '0; n_d = n_q; z_d = z_q; pend_d = pend_q;
    v = usr_q ? b_q : imm_q;
    if (cmd_q) begin
      nxt = pc;
      if (!pend_q) st = ST_NOLOAD;
      else begin
        pend_d = 1'b0;
        wr_idx = ldst_q; wr_val = ld_q; wr_rf = (ldst_q != PcIdx);
      end
    end else if (pend_q) begin
      st = ST_BUSY; nxt = pc;
    end else begin
      case (op_q)
        OP_LDR, OP_LDX: begin
          req = BUS_READ; pend_d = 1'b1;
          addr = (op_q == OP_LDR) ? tgt_q : b_q + off_q;
        end
        OP_STR, OP_STX: begin
          req = BUS_WRITE; wdata = d_q;
          addr = (op_q == OP_STR) ? tgt_q : b_q + off_q;
        end
        OP_MOV: begin
          if (rd_q == PcIdx) nxt = v;
          else begin wr_rf = 1'b1; wr_val = v; end
        end
        OP_ADD: begin r = a_q + b_q; alu = 1'b1; end
        OP_SUB: begin r = a_q - b_q; alu = 1'b1; end
        OP_MUL: begin r = prod[W-1:0]; alu = 1'b1; end
        OP_DIV: begin r = quot; alu = 1'b1; end
        OP_AND: begin r = a_q & b_q; alu = 1'b1; end
        OP_ORR: begin r = a_q | b_q; alu = 1'b1; end
        OP_EOR: begin r = a_q ^ b_q; alu = 1'b1; end
        OP_CMP: begin r = d_q - v; set_f = 1'b1; end
        OP_BR: begin
          case (cond_q)
            BC_AL: take = 1'b1;
            BC_EQ: take = z_q;
            BC_NE: take = !z_q;
            BC_LE: take = z_q || n_q;
            BC_LT: take = n_q;
            BC_GE: take = !n_q;
            BC_GT: take = !z_q && !n_q;
            default: begin take = 1'b1; wr_lr = 1'b1; end
          endcase
          if (take) nxt = tgt_q;
        end
        default: ;
      endcase
      if (alu) begin
        set_f = 1'b1; wr_val = r; wr_rf = (rd_q != PcIdx);
      end
      if (set_f) begin n_d = r[W-1]; z_d = (r == '0); end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) rf_q[i] <= '0;
      n_q <= 1'b0; z_q <= 1'b0; pend_q <= 1'b0; ldst_q <= '0;
    end else if (cmd_i.commit) begin
      if (wr_lr) rf_q[LrIdx] <= pc4;
      if (wr_rf) rf_q[wr_idx] <= wr_val;
      rf_q[PcIdx] <= nxt;
      n_q <= n_d; z_q <= z_d; pend_q <= pend_d;
      if (!cmd_q && !pend_q && (op_q == OP_LDR || op_q == OP_LDX)) ldst_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      next_pc_o        <= nar(nxt);
      bus_request_o    <= req;
      bus_address_o    <= nar(addr);
      bus_write_data_o <= nar(wdata);
      negative_flag_o  <= n_d;
      zero_flag_o      <= z_d;
      status_o         <= st;
    end
  end

endmodule
`default_nettype wire

@@ src/tcpu_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcpu_ctrl
// Sequencer for the execute unit: accept, divide, deliver.
// ----------------------------------------------------------------------------
module tcpu_ctrl import tcpu_pkg::*; (
  input  wire  logic     clk_i,
  input  wire  logic     rst_ni,
  input  wire  logic     in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire  logic     out_stall_i,
  input  wire  dp_stat_t stat_i,
  output dp_cmd_t        cmd_o
);
  ctrl_state_e state_q, state_d;
  logic        ov_q, ov_d;
  logic        div_q, div_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE; ov_q <= 1'b0; div_q <= 1'b0;
    end else begin
      state_q <= state_d; ov_q <= ov_d; div_q <= div_d;
    end
  end

  always_comb begin
    state_d = state_q; ov_d = ov_q; div_d = div_q; cmd_o = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    in_stall_o = (state_q != CS_IDLE);
    case (state_q)
      CS_IDLE: if (in_valid_i) begin
        cmd_o.capture = 1'b1; div_d = stat_i.needs_div; state_d = CS_DONE;
        if (stat_i.needs_div) state_d = CS_DIV;
      end
      CS_DIV: begin
        if (div_q) begin cmd_o.div_start = 1'b1; div_d = 1'b0; end
        else begin
          cmd_o.div_step = 1'b1;
          if (stat_i.div_last) state_d = CS_DONE;
        end
      end
      CS_DONE: if (!ov_q || !out_stall_i) begin
        cmd_o.commit = 1'b1; ov_d = 1'b1; state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;

  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!ov_q || !out_stall_i)) else $error("result overwritten");
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> in_stall_o) else $error("accepted while busy");
  a_div_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.div_step && cmd_o.commit)) else $error("commit during divide");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives decoded instructions and load-data beats into the execute unit and
// checks every result beat against an internal predictor of the register
// file, flags and pending-load state, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import tcpu_pkg::*;

  typedef struct packed {
    logic        command;
    logic [3:0]  opcode;
    logic [2:0]  cond;
    logic [3:0]  rd;
    logic [3:0]  rn;
    logic [3:0]  rm;
    logic        use_reg;
    logic [31:0] imm;
    logic [31:0] target;
    logic [31:0] offset;
    logic [31:0] ldata;
  } instr_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  req;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic        n;
    logic        z;
    logic [1:0]  status;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic command_i = 1'b0;
  logic [3:0] opcode_i = '0;
  logic [2:0] branch_condition_i = '0;
  logic [3:0] dest_reg_i = '0;
  logic [3:0] first_reg_i = '0;
  logic [3:0] second_reg_i = '0;
  logic use_register_i = 1'b0;
  logic signed [31:0] immediate_i = '0;
  logic [31:0] target_address_i = '0;
  logic signed [31:0] base_offset_i = '0;
  logic signed [31:0] load_data_i = '0;
  logic [31:0] next_pc_o;
  logic [1:0] bus_request_o;
  logic [31:0] bus_address_o;
  logic signed [31:0] bus_write_data_o;
  logic negative_flag_o;
  logic zero_flag_o;
  logic [1:0] status_o;

  tiny_cpu_execute_unit_top dut (.*);

  always #5 clk_i = ~clk_i;

  instr_t   pending_q[$];
  outcome_t expected_q[$];
  logic [31:0] regs [16];
  logic flag_n, flag_z, ld_busy;
  logic [3:0] ld_dest;
  int mismatches = 0;
  int cycles = 0;
  int idle_pct = 29;
  int hold_cycles = 0;
  bit hold_go = 1'b0;
  bit hold_seen = 1'b0;
  bit in_pause = 1'b0;

  function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    if (b == 0) return 0;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic outcome_t execute(instr_t it);
    outcome_t o;
    logic [31:0] pc, a, b, r, v;
    logic alu, take;
    pc = regs[PcIdx];
    a = regs[it.rm];
    b = regs[it.rn];
    r = 0;
    alu = 0;
    take = 0;
    o = '0;
    o.next_pc = pc + 4;
    if (it.command) begin
      if (!ld_busy) o.status = ST_NOLOAD;
      else begin
        if (ld_dest != PcIdx) regs[ld_dest] = it.ldata;
        ld_busy = 0;
      end
      o.next_pc = pc;
    end else if (ld_busy) begin
      o.status = ST_BUSY;
      o.next_pc = pc;
    end else begin
      case (opcode_e'(it.opcode))
        OP_LDR, OP_LDX: begin
          o.req = BUS_READ;
          o.addr = (it.opcode == OP_LDR) ? it.target : b + it.offset;
          ld_busy = 1;
          ld_dest = it.rd;
        end
        OP_STR, OP_STX: begin
          o.req = BUS_WRITE;
          o.addr = (it.opcode == OP_STR) ? it.target : b + it.offset;
          o.wdata = regs[it.rd];
        end
        OP_MOV: begin
          v = it.use_reg ? b : it.imm;
          if (it.rd == PcIdx) o.next_pc = v;
          else regs[it.rd] = v;
        end
        OP_ADD: begin r = a + b; alu = 1; end
        OP_SUB: begin r = a - b; alu = 1; end
        OP_MUL: begin r = a * b; alu = 1; end
        OP_DIV: begin r = quotient(a, b); alu = 1; end
        OP_AND: begin r = a & b; alu = 1; end
        OP_ORR: begin r = a | b; alu = 1; end
        OP_EOR: begin r = a ^ b; alu = 1; end
        OP_CMP: begin
          v = regs[it.rd] - (it.use_reg ? b : it.imm);
          flag_n = v[31];
          flag_z = (v == 0);
        end
        OP_BR: begin
          case (cond_e'(it.cond))
            BC_AL: take = 1;
            BC_EQ: take = flag_z;
            BC_NE: take = !flag_z;
            BC_LE: take = flag_z || flag_n;
            BC_LT: take = flag_n;
            BC_GE: take = !flag_n;
            BC_GT: take = !flag_z && !flag_n;
            default: begin
              regs[LrIdx] = pc + 4;
              take = 1;
            end
          endcase
          if (take) o.next_pc = it.target;
        end
        default: ;
      endcase
      if (alu) begin
        if (it.rd != PcIdx) regs[it.rd] = r;
        flag_n = r[31];
        flag_z = (r == 0);
      end
    end
    regs[PcIdx] = o.next_pc;
    o.n = flag_n;
    o.z = flag_z;
    return o;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t rand_instr(int unsigned max_op);
    instr_t it;
    it.command = 0;
    it.opcode = 4'($urandom_range(0, max_op));
    it.cond = 3'($urandom_range(0, 7));
    it.rd = 4'($urandom_range(0, 15));
    it.rn = 4'($urandom_range(0, 15));
    it.rm = 4'($urandom_range(0, 15));
    it.use_reg = 1'($urandom_range(0, 1));
    it.imm = rand_word();
    it.target = rand_word();
    it.offset = rand_word();
    it.ldata = rand_word();
    return it;
  endfunction

  // favor delivering data right after a load was queued
  function automatic bit ld_busy_hint(int i);
    return pending_q.size() > 0 && !pending_q[$].command
        && (pending_q[$].opcode == OP_LDR || pending_q[$].opcode == OP_LDX)
        && $urandom_range(0, 3) != 0;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_q.push_back(execute(pending_q.pop_front()));
    end
    if (in_valid_i && in_stall_o) begin
      // hold the stalled beat
    end else if (pending_q.size() > 0 && !in_pause
        && $urandom_range(0, 99) >= idle_pct) begin
      in_valid_i <= 1'b1;
      command_i <= pending_q[0].command;
      opcode_i <= pending_q[0].opcode;
      branch_condition_i <= pending_q[0].cond;
      dest_reg_i <= pending_q[0].rd;
      first_reg_i <= pending_q[0].rn;
      second_reg_i <= pending_q[0].rm;
      use_register_i <= pending_q[0].use_reg;
      immediate_i <= pending_q[0].imm;
      target_address_i <= pending_q[0].target;
      base_offset_i <= pending_q[0].offset;
      load_data_i <= pending_q[0].ldata;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver stall, with one long hold-off
  always @(posedge clk_i) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cycles <= 300;
      out_stall_i <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    outcome_t got, exp;
    cycles <= cycles + 1;
    if (out_valid_o && !out_stall_i) begin
      got = '{next_pc_o, bus_request_o, bus_address_o, bus_write_data_o,
              negative_flag_o, zero_flag_o, status_o};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        exp = expected_q.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", exp, got);
        end
      end
    end
    if (cycles > 400000) begin
      $display("** tiny_cpu_execute_unit_top: FAILED **");
      $finish;
    end
  end

  initial begin
    instr_t it;
    for (int i = 0; i < 16; i++) regs[i] = 0;
    flag_n = 0;
    flag_z = 0;
    ld_busy = 0;
    ld_dest = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: deliver with no load, extremes, div corner cases, all ops but NOP14
    it = rand_instr(0);
    it.command = 1;
    pending_q.push_back(it);
    for (int k = 0; k < 4; k++) begin
      it = rand_instr(0);
      it.opcode = OP_MOV;
      it.use_reg = 0;
      it.rd = 4'(k);
      it.imm = (k == 0) ? 32'h8000_0000 : (k == 1) ? 32'hFFFF_FFFF :
               (k == 2) ? 32'h0 : 32'h7FFF_FFFF;
      pending_q.push_back(it);
    end
    for (int k = OP_ADD; k <= OP_EOR; k++) begin
      it = rand_instr(0);
      it.opcode = 4'(k);
      it.rm = 0;
      it.rn = 4'((k == OP_DIV) ? 1 : 3);
      it.rd = 4'(4 + (k % 8));
      pending_q.push_back(it);
    end
    it.opcode = OP_DIV; it.rn = 2; it.rm = 3; it.rd = PcIdx;
    pending_q.push_back(it);
    it = rand_instr(0);
    it.opcode = OP_LDR; it.rd = 5;
    pending_q.push_back(it);
    it.opcode = OP_ADD;
    pending_q.push_back(it);
    it.command = 1;
    pending_q.push_back(it);
    it = rand_instr(0);
    it.opcode = OP_LDX; it.rd = PcIdx; it.rn = PcIdx;
    pending_q.push_back(it);
    it.command = 1;
    pending_q.push_back(it);
    it = rand_instr(0);
    it.opcode = OP_STX; it.rd = PcIdx; it.rn = 1;
    pending_q.push_back(it);
    it.opcode = OP_STR;
    pending_q.push_back(it);
    it = rand_instr(0);
    it.opcode = OP_CMP; it.rd = 0; it.use_reg = 0; it.imm = 32'h8000_0000;
    pending_q.push_back(it);
    it.opcode = OP_BR; it.cond = BC_BL;
    pending_q.push_back(it);
    it.opcode = OP_NOP15;
    pending_q.push_back(it);
    it.opcode = OP_MOV; it.rd = PcIdx; it.use_reg = 1; it.rn = 3;
    pending_q.push_back(it);

    // long receiver hold-off while the sender keeps offering
    for (int i = 0; i < 20; i++) pending_q.push_back(rand_instr(15));
    @(posedge clk_i);
    hold_go = 1'b1;
    wait (pending_q.size() == 0 && expected_q.size() == 0);

    // random traffic with a no-idle burst, a sender pause once drained, then more
    for (int i = 0; i < 520; i++) begin
      if (i == 200) begin
        idle_pct = 0;
      end
      if (i == 320) begin
        idle_pct = 29;
        wait (pending_q.size() == 0 && expected_q.size() == 0);
        in_pause = 1;
        repeat (40) @(posedge clk_i);
        in_pause = 0;
      end
      it = rand_instr(15);
      if (ld_busy_hint(i) || $urandom_range(0, 9) == 0) it.command = 1;
      pending_q.push_back(it);
      if (pending_q.size() > 8) wait (pending_q.size() <= 4);
    end
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("** tiny_cpu_execute_unit_top: PASSED **");
    end else begin
      $display("** tiny_cpu_execute_unit_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ tiny_cpu_execute_unit_top.f @@
src/tcpu_pkg.sv
src/tcpu_datapath.sv
src/tcpu_ctrl.sv
src/tiny_cpu_execute_unit_top.sv
tb/tb_top.sv
